FILE: sv/qct_pkg.sv
`timescale 1ns / 1ps
package qct_pkg;

  localparam int unsigned MAX_TIMERS = 4;
  localparam int unsigned NUM_TIMERS = 4;

  // Request codes.
  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_READ  = 2'd1,
    REQ_WRITE = 2'd2
  } req_e;

  // Byte position within one timer's four-byte slot.
  localparam logic [1:0] SUB_LO  = 2'd0;
  localparam logic [1:0] SUB_HI  = 2'd1;
  localparam logic [1:0] SUB_CTL = 2'd2;

  // Control byte bits.
  localparam int unsigned CTL_ENABLE_BIT  = 7;
  localparam int unsigned CTL_IRQ_BIT     = 6;
  localparam int unsigned CTL_CASCADE_BIT = 2;

  typedef struct packed {
    logic [1:0] req_type;
    logic [3:0] reg_offset;
    logic [7:0] write_data;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [3:0] overflow_mask;
    logic [3:0] irq_mask;
  } rsp_t;

  // Per-cell strobes from the decoder.
  typedef struct packed {
    logic tick;
    logic wr_lo;
    logic wr_hi;
    logic wr_ctl;
  } cell_ctl_t;

  // Per-cell event flags for this tick.
  typedef struct packed {
    logic wrap;
    logic irq;
  } cell_sts_t;

  // Prescaler terminal count for each select code.
  function automatic logic [10:0] prescale_limit(input logic [1:0] sel);
    logic [10:0] lim;
    case (sel)
      2'd0:    lim = 11'd1;
      2'd1:    lim = 11'd64;
      2'd2:    lim = 11'd256;
      default: lim = 11'd1024;
    endcase
    return lim;
  endfunction

endpackage

FILE: sv/quad_cascade_timer_core.sv
`timescale 1ns / 1ps
// Quad cascadable 16-bit timer block with prescalers.
//
// Input channel (in_valid_i / in_ready_o / in_word_i): each word is a clock
// tick, a byte read or a byte write into the 16-byte register window
// (timer = offset[3:2]; bytes: reload/count low, high, control, unused).
// Output channel (out_valid_o / out_ready_i / out_word_o): one word per input
// word, in order, carrying the read byte and the overflow and interrupt
// masks of that tick.
//
// Each word is decoded, the timer cells update and the result is captured in
// the output register at the same edge. Throughput is one word per cycle
// while the receiver does not stall; a wrap ripples through the chain of
// timer cells within the same cycle, so the cascade path (four 16-bit
// all-ones compares and an AND chain) sets the clock period.
//
// Reset clears all counters, reload values, control bytes and prescalers and
// empties the output register. When the receiver stalls, the output word
// holds and in_ready_o drops until it is taken; the input is still accepted
// in the same cycle the held word leaves.
module quad_cascade_timer_core #(
  parameter int unsigned NumTimers = qct_pkg::NUM_TIMERS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  qct_pkg::req_t in_word_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output qct_pkg::rsp_t out_word_o
);
  import qct_pkg::*;

  logic        in_acc;
  logic [1:0]  sel_timer;
  logic [1:0]  sel_sub;
  logic        is_tick, is_read, is_write;

  logic [15:0] count_w [MAX_TIMERS];
  logic [7:0]  ctrl_w  [MAX_TIMERS];
  logic [3:0]  wrap_w;
  logic [3:0]  irq_w;

  logic        out_valid_q, out_valid_d;
  rsp_t        out_word_q, out_word_d;
  logic [7:0]  rd_byte;

  // Take a new word whenever the output register is empty or draining.
  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign in_acc     = in_valid_i & in_ready_o;

  assign sel_timer = in_word_i.reg_offset[3:2];
  assign sel_sub   = in_word_i.reg_offset[1:0];
  assign is_tick   = in_acc & (in_word_i.req_type == REQ_TICK);
  assign is_read   = in_acc & (in_word_i.req_type == REQ_READ);
  assign is_write  = in_acc & (in_word_i.req_type == REQ_WRITE);

  // Build the chain: each cell hands its wrap to the right neighbor as carry.
  for (genvar t = 0; t < MAX_TIMERS; t++) begin : g_cell
    if (t < NumTimers) begin : g_live
      cell_ctl_t  ctl;
      cell_sts_t  sts;
      logic       carry_in;
      logic       hit_me;

      assign hit_me     = is_write & (sel_timer == t[1:0]);
      assign ctl.tick   = is_tick;
      assign ctl.wr_lo  = hit_me & (sel_sub == SUB_LO);
      assign ctl.wr_hi  = hit_me & (sel_sub == SUB_HI);
      assign ctl.wr_ctl = hit_me & (sel_sub == SUB_CTL);

      if (t == 0) begin : g_head
        // Nothing feeds the first timer.
        assign carry_in = 1'b0;
      end else begin : g_link
        assign carry_in = wrap_w[t-1];
      end

      qct_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .ctl_i   (ctl),
        .wdata_i (in_word_i.write_data),
        .carry_i (carry_in),
        .sts_o   (sts),
        .count_o (count_w[t]),
        .ctrl_o  (ctrl_w[t])
      );

      assign wrap_w[t] = sts.wrap;
      assign irq_w[t]  = sts.irq;
    end else begin : g_absent
      // Absent timers read as zero and never wrap.
      assign count_w[t] = '0;
      assign ctrl_w[t]  = '0;
      assign wrap_w[t]  = 1'b0;
      assign irq_w[t]   = 1'b0;
    end
  end

  // Read mux; the unused byte reads as zero.
  always_comb begin
    case (sel_sub)
      SUB_LO:  rd_byte = count_w[sel_timer][7:0];
      SUB_HI:  rd_byte = count_w[sel_timer][15:8];
      SUB_CTL: rd_byte = ctrl_w[sel_timer];
      default: rd_byte = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_word_d  = out_word_q;
    if (in_acc) begin
      out_valid_d              = 1'b1;
      out_word_d.read_data     = is_read ? rd_byte : '0;
      out_word_d.overflow_mask = is_tick ? wrap_w : '0;
      out_word_d.irq_mask      = is_tick ? irq_w : '0;
    end else if (out_ready_i) begin
      // Drop the word once the receiver has taken it.
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

`ifndef SYNTH
  a_no_take_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !in_ready_o)
    else $error("input taken while output word stalled");

  a_irq_within_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_word_o.irq_mask & ~out_word_o.overflow_mask) == 4'd0))
    else $error("interrupt flagged without overflow");

  a_bus_no_events: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_word_i.req_type != REQ_TICK) |=>
    (out_word_o.overflow_mask == 4'd0 && out_word_o.irq_mask == 4'd0))
    else $error("events reported on a bus access");

  a_tick_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_word_i.req_type == REQ_TICK) |=>
    (out_valid_o && out_word_o.read_data == 8'd0))
    else $error("tick result lost or carries read data");
`endif

endmodule

FILE: sv/qct_cell.sv
`timescale 1ns / 1ps
module qct_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  qct_pkg::cell_ctl_t ctl_i,
  input  logic [7:0]         wdata_i,
  input  logic               carry_i,
  output qct_pkg::cell_sts_t sts_o,
  output logic [15:0]        count_o,
  output logic [7:0]         ctrl_o
);
  import qct_pkg::*;

  logic [15:0] count_q, count_d;
  logic [15:0] reload_q, reload_d;
  logic [7:0]  ctrl_q, ctrl_d;
  logic [9:0]  pre_q, pre_d;

  logic        en, casc, free_run, hit, bump, wrap, start;
  logic [10:0] pre_sum;

  assign en       = ctrl_q[CTL_ENABLE_BIT];
  assign casc     = ctrl_q[CTL_CASCADE_BIT];
  assign free_run = ctl_i.tick & en & ~casc;
  assign pre_sum  = {1'b0, pre_q} + 11'd1;
  assign hit      = pre_sum >= prescale_limit(ctrl_q[1:0]);
  // Advance on own prescaler, or on a carry from the left neighbor when chained.
  assign bump     = (free_run & hit) | (carry_i & en & casc);
  assign wrap     = bump & (count_q == 16'hFFFF);
  assign start    = ctl_i.wr_ctl & ~en & wdata_i[CTL_ENABLE_BIT];

  always_comb begin
    count_d  = count_q;
    reload_d = reload_q;
    ctrl_d   = ctrl_q;
    pre_d    = pre_q;
    if (start) begin
      count_d = reload_q;
      pre_d   = '0;
    end else if (bump) begin
      count_d = wrap ? reload_q : count_q + 16'd1;
    end
    if (free_run) begin
      pre_d = hit ? '0 : pre_sum[9:0];
    end
    if (ctl_i.wr_lo) begin
      reload_d = {reload_q[15:8], wdata_i};
    end
    if (ctl_i.wr_hi) begin
      reload_d = {wdata_i, reload_q[7:0]};
    end
    if (ctl_i.wr_ctl) begin
      ctrl_d = wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      reload_q <= '0;
      ctrl_q   <= '0;
      pre_q    <= '0;
    end else begin
      count_q  <= count_d;
      reload_q <= reload_d;
      ctrl_q   <= ctrl_d;
      pre_q    <= pre_d;
    end
  end

  assign sts_o.wrap = wrap;
  assign sts_o.irq  = wrap & ctrl_q[CTL_IRQ_BIT];
  assign count_o    = count_q;
  assign ctrl_o     = ctrl_q;

endmodule
